// ----- rtl/aes128_block_decrypt_core_defines.svh -----
// Assertion macros used by the checker file.
`ifndef AES128_BLOCK_DECRYPT_CORE_DEFINES_SVH
`define AES128_BLOCK_DECRYPT_CORE_DEFINES_SVH

// Clocked assertion, muted while reset is low
`define AD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds through reset
`define AD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/aesd_pkg.sv -----
`default_nettype none
package aesd_pkg;

  localparam int NumRounds = 10;
  localparam int KeyCntW = $clog2(NumRounds + 1);

  // Configuration register indexes
  localparam logic [7:0] RegKeyHigh = 8'd0;
  localparam logic [7:0] RegKeyLow  = 8'd1;

  typedef logic [127:0] blk_t;
  typedef logic [NumRounds:0][127:0] rk_set_t;

  localparam logic [7:0] InvSbox [0:255] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
  };

  localparam logic [7:0] FwdSbox [0:255] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  // Round constant for key expansion step n (1 to 10)
  function automatic logic [7:0] rcon(input logic [KeyCntW-1:0] n);
    logic [7:0] r;
    case (n)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1B;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Byte n of a block, byte 0 in the top bits
  function automatic logic [7:0] get_byte(input blk_t b, input int n);
    return b[127-8*n -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  // Inverse row shift followed by inverse substitution
  function automatic blk_t inv_shift_sub(input blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = InvSbox[get_byte(s, 4*((c-r+4)%4)+r)];
      end
    end
    return t;
  endfunction

  function automatic blk_t inv_mix(input blk_t s);
    blk_t t;
    logic [7:0] a [0:3];
    logic [7:0] x2 [0:3];
    logic [7:0] x4 [0:3];
    logic [7:0] x8 [0:3];
    logic [7:0] m9 [0:3];
    logic [7:0] m11 [0:3];
    logic [7:0] m13 [0:3];
    logic [7:0] m14 [0:3];
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        a[i]   = get_byte(s, 4*c+i);
        x2[i]  = xtime(a[i]);
        x4[i]  = xtime(x2[i]);
        x8[i]  = xtime(x4[i]);
        m9[i]  = x8[i] ^ a[i];
        m11[i] = x8[i] ^ x2[i] ^ a[i];
        m13[i] = x8[i] ^ x4[i] ^ a[i];
        m14[i] = x8[i] ^ x4[i] ^ x2[i];
      end
      t[127-8*(4*c)   -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
      t[127-8*(4*c+1) -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
      t[127-8*(4*c+2) -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
      t[127-8*(4*c+3) -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
    end
    return t;
  endfunction

  // One step of AES-128 key expansion
  function automatic blk_t key_step(input blk_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    blk_t o;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {FwdSbox[w3[23:16]] ^ rc, FwdSbox[w3[15:8]], FwdSbox[w3[7:0]], FwdSbox[w3[31:24]]};
    o[127:96] = w0 ^ t;
    o[95:64]  = w1 ^ o[127:96];
    o[63:32]  = w2 ^ o[95:64];
    o[31:0]   = w3 ^ o[63:32];
    return o;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/aesd_keyexp.sv -----
`default_nettype none
module aesd_keyexp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_index,
  input  logic [63:0]      cfg_data,
  output logic             busy,
  output aesd_pkg::rk_set_t rkeys
);
  import aesd_pkg::*;

  logic [63:0]        key_hi_r;
  logic [63:0]        key_lo_r;
  logic               busy_r;
  logic [KeyCntW-1:0] cnt_r;
  blk_t               prev_r;
  rk_set_t            rk_r;
  blk_t               step_nxt;

  assign cfg_ready = !busy_r;
  assign busy      = busy_r;
  assign rkeys     = rk_r;
  assign step_nxt  = key_step(prev_r, rcon(cnt_r));

  // Take key writes and sequence the expansion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      busy_r   <= 1'b1;
      cnt_r    <= '0;
    end else if (busy_r) begin
      if (cnt_r == KeyCntW'(NumRounds)) busy_r <= 1'b0;
      cnt_r <= cnt_r + 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == RegKeyHigh) begin
        key_hi_r <= cfg_data;
        busy_r   <= 1'b1;
        cnt_r    <= '0;
      end else if (cfg_index == RegKeyLow) begin
        key_lo_r <= cfg_data;
        busy_r   <= 1'b1;
        cnt_r    <= '0;
      end
    end
  end

  // Produce one round key per cycle while busy
  always_ff @(posedge clk) begin
    if (busy_r) begin
      if (cnt_r == '0) begin
        rk_r[0] <= {key_hi_r, key_lo_r};
        prev_r  <= {key_hi_r, key_lo_r};
      end else begin
        rk_r[cnt_r] <= step_nxt;
        prev_r      <= step_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/aesd_round.sv -----
`default_nettype none
module aesd_round (
  input  aesd_pkg::blk_t state_in,
  input  aesd_pkg::blk_t rkey,
  output aesd_pkg::blk_t state_out
);
  import aesd_pkg::*;

  // Middle round: shift and substitute, add key, mix
  assign state_out = inv_mix(inv_shift_sub(state_in) ^ rkey);

endmodule
`default_nettype wire

// ----- rtl/aes128_block_decrypt_core.sv -----
`default_nettype none
// Channel  | Direction | Ports
// in       | input     | in_valid, in_stall, in_cipher_high, in_cipher_low
// out      | output    | out_valid, out_stall, out_plain_high, out_plain_low
// cfg      | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// Eleven register stages, one per AES round step; one block per cycle while no stall holds the pipeline.
// Reset and every write to a key register run the key expansion, one round key a cycle;
// in_stall and !cfg_ready hold during it.
// Out stall backs up only as far as the first empty stage; bubbles are squeezed out.
module aes128_block_decrypt_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_cipher_high,
  input  logic [63:0] in_cipher_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_plain_high,
  output logic [63:0] out_plain_low,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import aesd_pkg::*;

  logic              kbusy;
  rk_set_t           rkeys;
  logic [NumRounds:0] v_r;
  blk_t              d_r [0:NumRounds];
  blk_t              rnd [1:NumRounds-1];
  logic [NumRounds+1:0] rdy;

  aesd_keyexp u_keyexp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (kbusy),
    .rkeys     (rkeys)
  );

  // Middle rounds
  for (genvar k = 1; k < NumRounds; k++) begin : g_round
    aesd_round u_round (
      .state_in  (d_r[k-1]),
      .rkey      (rkeys[NumRounds-k]),
      .state_out (rnd[k])
    );
  end

  // A stage may load when empty or when it moves on
  always_comb begin
    rdy[NumRounds+1] = !out_stall;
    for (int i = NumRounds; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[0] || kbusy;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid && !kbusy;
      for (int i = 1; i <= NumRounds; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // Advance data
  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid && !kbusy) begin
      d_r[0] <= {in_cipher_high, in_cipher_low} ^ rkeys[NumRounds];
    end
    for (int i = 1; i < NumRounds; i++) begin
      if (rdy[i] && v_r[i-1]) d_r[i] <= rnd[i];
    end
    if (rdy[NumRounds] && v_r[NumRounds-1]) begin
      d_r[NumRounds] <= inv_shift_sub(d_r[NumRounds-1]) ^ rkeys[0];
    end
  end

  assign out_valid      = v_r[NumRounds];
  assign out_plain_high = d_r[NumRounds][127:64];
  assign out_plain_low  = d_r[NumRounds][63:0];

endmodule
`default_nettype wire

// ----- rtl/aesd_checker.sv -----
`default_nettype none
`include "aes128_block_decrypt_core_defines.svh"
module aesd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_plain_high,
  input logic [63:0] out_plain_low,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [7:0]  cfg_index
);
  import aesd_pkg::*;

  // Stalled result holds
  `AD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_plain_high) && $stable(out_plain_low), "stalled result changed")

  // Key write starts the expansion, which blocks input
  `AD_ASSERT(a_cfg_blocks_in, cfg_valid && cfg_ready && (cfg_index == RegKeyHigh || cfg_index == RegKeyLow) |=> in_stall, "input taken during key expansion")

  // Key write is followed by a busy port
  `AD_ASSERT(a_cfg_busy, cfg_valid && cfg_ready && (cfg_index == RegKeyHigh || cfg_index == RegKeyLow) |=> !cfg_ready, "config taken during key expansion")

  // Reset expands the zero key before any input
  `AD_ASSERT_RST(a_rst_blocks_in, !rst_n |=> in_stall, "input taken right after reset")

endmodule

bind aes128_block_decrypt_core aesd_checker u_aesd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_plain_high (out_plain_high),
  .out_plain_low  (out_plain_low),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready),
  .cfg_index      (cfg_index)
);
`default_nettype wire
